// File: design/assert_macros.svh
// Assertion macros used by the checker file of the tile gap remapper.
// Include this header by its bare file name; it defines nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TGI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked around reset.
`define TGI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/tgi_pkg.sv
// Package for the tile gap remapper: limits, register codes, beat and
// configuration structs, and gap helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgi_pkg;

  localparam int MAX_GRID   = 7;
  localparam int MAX_CHIP   = 1024;
  localparam int PIXEL_BITS = 16;
  localparam int GAP_BITS   = 8;

  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 64;

  localparam logic [7:0]  GAP_MASK = 8'((1 << GAP_BITS) - 1);
  localparam logic [15:0] PIX_MASK = (PIXEL_BITS >= 16) ? 16'hFFFF :
                                     16'((1 << PIXEL_BITS) - 1);

  typedef enum logic [2:0] {
    REG_GRID_ROWS = 3'd0,
    REG_GRID_COLS = 3'd1,
    REG_CHIP_ROWS = 3'd2,
    REG_CHIP_COLS = 3'd3,
    REG_GAPS_X    = 3'd4,
    REG_GAPS_Y    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  grid_rows;
    logic [2:0]  grid_cols;
    logic [10:0] chip_rows;
    logic [10:0] chip_cols;
    logic [63:0] gaps_x;
    logic [63:0] gaps_y;
    logic        ok;         // grid and chip sizes inside their limits
    logic [13:0] width;      // gapped output width, 0 when not ok
    logic [13:0] height;     // gapped output height, 0 when not ok
    logic [13:0] rows_prod;  // grid_rows * chip_rows
    logic [13:0] cols_prod;  // grid_cols * chip_cols
  } cfg_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        frame_start;
    logic [12:0] frame_height;
    logic [12:0] frame_width;
  } item_t;

  typedef struct packed {
    logic [26:0] dest_address;
    logic [15:0] pixel_out;
    logic        write_enable;
    logic        frame_last;
    logic [13:0] out_width;
    logic [13:0] out_height;
  } result_t;

  function automatic logic [7:0] gap_of(input logic [63:0] packed_gaps,
                                        input logic [2:0]  idx);
    return packed_gaps[{idx, 3'b000} +: 8] & GAP_MASK;
  endfunction

  // Sum of the gaps before each tile and after the last one.
  function automatic logic [10:0] gap_sum(input logic [2:0]  grid,
                                          input logic [63:0] packed_gaps);
    logic [10:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      if (i <= int'(grid)) begin
        s = s + {3'b000, gap_of(packed_gaps, 3'(i))};
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/tgi_cfg.sv
// Configuration registers of the tile gap remapper on an APB-style port,
// plus a registered stage of frame sizes derived from them. Uses tgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgi_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tgi_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [tgi_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [tgi_pkg::DATA_BITS-1:0]  prdata,
  output tgi_pkg::cfg_t                       cfg
);

  logic [2:0]  grid_rows;
  logic [2:0]  grid_cols;
  logic [10:0] chip_rows;
  logic [10:0] chip_cols;
  logic [63:0] gaps_x;
  logic [63:0] gaps_y;

  logic        ok;
  logic [13:0] width;
  logic [13:0] height;
  logic [13:0] rows_prod;
  logic [13:0] cols_prod;

  logic        ok_next;
  logic [13:0] width_next;
  logic [13:0] height_next;
  logic [13:0] rows_prod_next;
  logic [13:0] cols_prod_next;

  tgi_pkg::reg_idx_t idx;
  logic              wr;

  assign idx = tgi_pkg::reg_idx_t'(paddr[5:3]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 3'd1;
      grid_cols <= 3'd1;
      chip_rows <= 11'd256;
      chip_cols <= 11'd256;
      gaps_x    <= '0;
      gaps_y    <= '0;
    end else if (wr) begin
      case (idx)
        tgi_pkg::REG_GRID_ROWS: grid_rows <= pwdata[2:0];
        tgi_pkg::REG_GRID_COLS: grid_cols <= pwdata[2:0];
        tgi_pkg::REG_CHIP_ROWS: chip_rows <= pwdata[10:0];
        tgi_pkg::REG_CHIP_COLS: chip_cols <= pwdata[10:0];
        tgi_pkg::REG_GAPS_X:    gaps_x    <= pwdata;
        tgi_pkg::REG_GAPS_Y:    gaps_y    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tgi_pkg::REG_GRID_ROWS: prdata = {61'b0, grid_rows};
      tgi_pkg::REG_GRID_COLS: prdata = {61'b0, grid_cols};
      tgi_pkg::REG_CHIP_ROWS: prdata = {53'b0, chip_rows};
      tgi_pkg::REG_CHIP_COLS: prdata = {53'b0, chip_cols};
      tgi_pkg::REG_GAPS_X:    prdata = gaps_x;
      tgi_pkg::REG_GAPS_Y:    prdata = gaps_y;
      default:                prdata = '0;
    endcase
  end

  // Derived sizes are registered from the configuration registers and are settled
  // before any beat that follows a write reaches the address logic.
  always_comb begin
    ok_next = (grid_rows != 3'd0) && (grid_rows <= 3'(tgi_pkg::MAX_GRID)) &&
              (grid_cols != 3'd0) && (grid_cols <= 3'(tgi_pkg::MAX_GRID)) &&
              (chip_rows != 11'd0) && (chip_rows <= 11'(tgi_pkg::MAX_CHIP)) &&
              (chip_cols != 11'd0) && (chip_cols <= 11'(tgi_pkg::MAX_CHIP));
    rows_prod_next = {11'b0, grid_rows} * {3'b0, chip_rows};
    cols_prod_next = {11'b0, grid_cols} * {3'b0, chip_cols};
    width_next  = '0;
    height_next = '0;
    if (ok_next) begin
      width_next  = cols_prod_next + {3'b0, tgi_pkg::gap_sum(grid_cols, gaps_x)};
      height_next = rows_prod_next + {3'b0, tgi_pkg::gap_sum(grid_rows, gaps_y)};
    end
  end

  always_ff @(posedge clk) begin
    ok        <= ok_next;
    width     <= width_next;
    height    <= height_next;
    rows_prod <= rows_prod_next;
    cols_prod <= cols_prod_next;
  end

  always_comb begin
    cfg.grid_rows = grid_rows;
    cfg.grid_cols = grid_cols;
    cfg.chip_rows = chip_rows;
    cfg.chip_cols = chip_cols;
    cfg.gaps_x    = gaps_x;
    cfg.gaps_y    = gaps_y;
    cfg.ok        = ok;
    cfg.width     = width;
    cfg.height    = height;
    cfg.rows_prod = rows_prod;
    cfg.cols_prod = cols_prod;
  end

endmodule

`default_nettype wire

// File: design/tgi_core.sv
// Position counters and gapped address logic of the tile gap remapper.
// Uses tgi_pkg; fed by tgi_cfg and the input register of the top level.
`timescale 1ns / 1ps
`default_nettype none

module tgi_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tgi_pkg::cfg_t    cfg,
  input  wire tgi_pkg::item_t   item,
  input  wire logic             advance,
  output tgi_pkg::result_t      res
);

  logic [9:0]  col_in_chip;
  logic [2:0]  tile_col;
  logic [9:0]  row_in_chip;
  logic [2:0]  tile_row;
  logic [10:0] x_gap_sum;
  logic [26:0] row_base_address;
  logic        frame_ok;
  logic [13:0] width_reg;
  logic [13:0] height_reg;

  logic [9:0]  col_in_chip_next;
  logic [2:0]  tile_col_next;
  logic [9:0]  row_in_chip_next;
  logic [2:0]  tile_row_next;
  logic [10:0] x_gap_sum_next;
  logic [26:0] row_base_address_next;
  logic        frame_ok_next;
  logic [13:0] width_reg_next;
  logic [13:0] height_reg_next;

  // Effective state: a frame start overrides the stored position, frame_ok and sizes.
  logic [9:0]  col_e;
  logic [2:0]  tcol_e;
  logic [9:0]  row_e;
  logic [2:0]  trow_e;
  logic [10:0] xsum_e;
  logic [26:0] rbase_e;
  logic        ok_e;
  logic [13:0] width_e;
  logic [13:0] height_e;

  logic [7:0]  gx0;
  logic [7:0]  gy0;
  logic [21:0] row0_prod;
  logic [21:0] ystep_prod;
  logic [13:0] col_off;
  logic [10:0] col_inc;
  logic [3:0]  tcol_inc;
  logic [10:0] row_inc;
  logic [3:0]  trow_inc;
  logic [26:0] rb_step;
  logic        last;

  always_comb begin
    gx0       = tgi_pkg::gap_of(cfg.gaps_x, 3'd0);
    gy0       = tgi_pkg::gap_of(cfg.gaps_y, 3'd0);
    row0_prod = {14'b0, gy0} * {8'b0, cfg.width};

    if (item.frame_start) begin
      col_e    = '0;
      tcol_e   = '0;
      row_e    = '0;
      trow_e   = '0;
      xsum_e   = {3'b000, gx0};
      rbase_e  = {5'b0, row0_prod};
      ok_e     = cfg.ok && ({1'b0, item.frame_height} == cfg.rows_prod) &&
                 ({1'b0, item.frame_width} == cfg.cols_prod);
      width_e  = cfg.width;
      height_e = cfg.height;
    end else begin
      col_e    = col_in_chip;
      tcol_e   = tile_col;
      row_e    = row_in_chip;
      trow_e   = tile_row;
      xsum_e   = x_gap_sum;
      rbase_e  = row_base_address;
      ok_e     = frame_ok;
      width_e  = width_reg;
      height_e = height_reg;
    end

    col_off    = {11'b0, tcol_e} * {3'b0, cfg.chip_cols};
    col_inc    = {1'b0, col_e} + 11'd1;
    tcol_inc   = {1'b0, tcol_e} + 4'd1;
    row_inc    = {1'b0, row_e} + 11'd1;
    trow_inc   = {1'b0, trow_e} + 4'd1;
    rb_step    = rbase_e + {13'b0, width_e};
    ystep_prod = {14'b0, tgi_pkg::gap_of(cfg.gaps_y, trow_inc[2:0])} * {8'b0, width_e};

    col_in_chip_next      = col_e;
    tile_col_next         = tcol_e;
    row_in_chip_next      = row_e;
    tile_row_next         = trow_e;
    x_gap_sum_next        = xsum_e;
    row_base_address_next = rbase_e;
    frame_ok_next         = ok_e;
    width_reg_next        = width_e;
    height_reg_next       = height_e;
    last                  = 1'b0;

    if (ok_e) begin
      if (col_inc < cfg.chip_cols) begin
        col_in_chip_next = col_inc[9:0];
      end else begin
        col_in_chip_next = '0;
        if (tcol_inc < {1'b0, cfg.grid_cols}) begin
          tile_col_next  = tcol_inc[2:0];
          x_gap_sum_next = xsum_e + {3'b000, tgi_pkg::gap_of(cfg.gaps_x, tcol_inc[2:0])};
        end else begin
          tile_col_next         = '0;
          x_gap_sum_next        = {3'b000, gx0};
          row_base_address_next = rb_step;
          if (row_inc < cfg.chip_rows) begin
            row_in_chip_next = row_inc[9:0];
          end else begin
            row_in_chip_next = '0;
            if (trow_inc < {1'b0, cfg.grid_rows}) begin
              tile_row_next         = trow_inc[2:0];
              row_base_address_next = rb_step + {5'b0, ystep_prod};
            end else begin
              tile_row_next = '0;
              last          = 1'b1;
              frame_ok_next = 1'b0;
            end
          end
        end
      end
    end

    res.dest_address = ok_e ? (rbase_e + {13'b0, col_off} + {17'b0, col_e} +
                               {16'b0, xsum_e}) : '0;
    res.pixel_out    = item.pixel_value & tgi_pkg::PIX_MASK;
    res.write_enable = ok_e;
    res.frame_last   = last;
    res.out_width    = width_e;
    res.out_height   = height_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_in_chip      <= '0;
      tile_col         <= '0;
      row_in_chip      <= '0;
      tile_row         <= '0;
      x_gap_sum        <= '0;
      row_base_address <= '0;
      frame_ok         <= 1'b0;
      width_reg        <= '0;
      height_reg       <= '0;
    end else if (advance) begin
      col_in_chip      <= col_in_chip_next;
      tile_col         <= tile_col_next;
      row_in_chip      <= row_in_chip_next;
      tile_row         <= tile_row_next;
      x_gap_sum        <= x_gap_sum_next;
      row_base_address <= row_base_address_next;
      frame_ok         <= frame_ok_next;
      width_reg        <= width_reg_next;
      height_reg       <= height_reg_next;
    end
  end

endmodule

`default_nettype wire

// File: design/tile_gap_insertion_remap.sv
// A pixel beat taken on the slave side is held in the input register, and its result beat
// is registered into the output register once that register is empty or m_tready is high.
// Throughput: one pixel per cycle while m_tready does not stall the output, set by the single
// pass of counter and address logic between the input and output registers.
// Reset (rst, synchronous): empties both registers, clears position state and frame_ok,
// and returns the configuration registers to their defaults; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tile_gap_insertion_remap (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // slave side
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [47:0]                   s_tdata,  // pixel_value, frame_height, frame_width
  input  wire logic                          s_tuser,  // frame_start
  // master side
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [71:0]                   m_tdata,  // dest_address, pixel_out, out_width,
                                                       // out_height
  output logic                               m_tlast,  // frame_last
  output logic                               m_tuser,  // write_enable
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tgi_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [tgi_pkg::DATA_BITS-1:0] pwdata,
  output logic      [tgi_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready
);

  tgi_pkg::cfg_t    cfg;
  tgi_pkg::item_t   in_item;
  tgi_pkg::result_t core_res;
  tgi_pkg::result_t out_res;

  logic in_valid;
  logic out_valid;
  logic out_free;
  logic advance;

  assign pready   = 1'b1;
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  tgi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tgi_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (in_item),
    .advance (advance),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.pixel_value  <= s_tdata[15:0];
      in_item.frame_start  <= s_tuser;
      in_item.frame_height <= s_tdata[28:16];
      in_item.frame_width  <= s_tdata[41:29];
    end
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.out_height, out_res.out_width, out_res.pixel_out,
                     out_res.dest_address};
  assign m_tlast  = out_res.frame_last;
  assign m_tuser  = out_res.write_enable;

endmodule

`default_nettype wire

// File: design/tgi_checker.sv
// Port-level checker for the tile gap remapper and its bind to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tgi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  // A stalled result beat stays put.
  `TGI_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result beat changed while stalled")

  // The end of a frame is only marked on written pixels.
  `TGI_ASSERT(a_last_written, clk, rst, m_tvalid && m_tlast |-> m_tuser, "frame_last on a rejected pixel")

  // Pixels of a rejected frame carry address zero.
  `TGI_ASSERT(a_reject_addr, clk, rst, m_tvalid && !m_tuser |-> m_tdata[26:0] == 27'd0, "nonzero address with writes disabled")

  // With no result waiting the pipeline always has room.
  `TGI_ASSERT(a_room, clk, rst, !m_tvalid |-> s_tready, "input stalled with empty output")

  // Reset leaves both sides empty and ready.
  `TGI_ASSERT_ALWAYS(a_reset_empty, clk, !rst && $past(rst) |-> !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule

bind tile_gap_insertion_remap tgi_checker u_tgi_checker (.*);

`default_nettype wire
